[rtl/fan_coil_thermostat_control_assert.svh]
// assertion macros for the fan-coil thermostat block
`ifndef FAN_COIL_THERMOSTAT_CONTROL_ASSERT_SVH
`define FAN_COIL_THERMOSTAT_CONTROL_ASSERT_SVH

// same-cycle implication, sampled on clk, off during reset
`define FCTC_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, sampled on clk, off during reset
`define FCTC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/fctc_pkg.sv]
// shared types, constants and temperature helpers of the fan-coil thermostat
`default_nettype none

package fctc_pkg;

  // zones and field widths
  localparam int ZONE_COUNT = 4;
  localparam int ZONE_W     = 2;
  localparam int TEMP_W     = 8;
  localparam int TENTHS_W   = 11;
  localparam int SPEED_W    = 2;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 8;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_SETBACK_OFFSET    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_EMPTY_HEAT_REF    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_EMPTY_COOL_REF    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_FIXED_SPEEDS      = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_SIMULTANEOUS_MASK = 3'd4;

  // difference band limits in tenths
  localparam logic [TENTHS_W-1:0] BAND_DEAD = 11'd9;
  localparam logic [TENTHS_W-1:0] BAND_LOW  = 11'd19;
  localparam logic [TENTHS_W-1:0] BAND_MID  = 11'd29;
  localparam logic [TENTHS_W-1:0] BAND_HIGH = 11'd30;

  // fan speeds
  localparam logic [SPEED_W-1:0] SPEED_OFF  = 2'd0;
  localparam logic [SPEED_W-1:0] SPEED_LOW  = 2'd1;
  localparam logic [SPEED_W-1:0] SPEED_MID  = 2'd2;
  localparam logic [SPEED_W-1:0] SPEED_HIGH = 2'd3;

  // reported zone mode
  typedef enum logic [1:0] {
    MODE_EMPTY   = 2'd0,
    MODE_SETBACK = 2'd1,
    MODE_STAY    = 2'd2
  } zone_mode_t;

  // whole degrees plus half bit to tenths
  function automatic logic [TENTHS_W-1:0] tenths(input logic [TEMP_W-1:0] t);
    logic [TENTHS_W-1:0] w;
    w = {4'b0, t[6:0]};
    return (w << 3) + (w << 1) + (t[7] ? 11'd5 : 11'd0);
  endfunction

  // two bcd digits of whole degrees to tenths, digits above nine not checked
  function automatic logic [TENTHS_W-1:0] bcd_tenths(input logic [7:0] b);
    logic [TENTHS_W-1:0] hi;
    logic [TENTHS_W-1:0] deg;
    hi  = {7'b0, b[7:4]};
    deg = (hi << 3) + (hi << 1) + {7'b0, b[3:0]};
    return (deg << 3) + (deg << 1);
  endfunction

endpackage

`default_nettype wire

[rtl/fan_coil_thermostat_control.sv]
// fan-coil thermostat: per-zone fan speed and mode tracking, two-register pipeline
// Takes one zone word per clock unless stalled; returns one result word per input
// word via the input register, then the result register. The decision is a single
// compare-and-select pass between them, so unstalled throughput is one word per
// cycle; per-zone fan speed and mode are updated in the same cycle the result is
// registered, so a following word for the same zone sees them at once. in_ready
// depends combinationally on out_ready. Configuration writes are always accepted
// (cfg_ready is tied high) and must only be issued while the block is idle.
`default_nettype none

module fan_coil_thermostat_control (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  // configuration write channel
  input  wire logic                               cfg_valid,
  output logic                                    cfg_ready,
  input  wire logic [fctc_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [fctc_pkg::CFG_DATA_W-1:0]    cfg_data,
  // input channel
  input  wire logic                               in_valid,
  output logic                                    in_ready,
  input  wire logic [fctc_pkg::ZONE_W-1:0]        in_zone,
  input  wire logic                               in_trigger,
  input  wire logic [fctc_pkg::TEMP_W-1:0]        in_set_temp,
  input  wire logic [fctc_pkg::TEMP_W-1:0]        in_current_temp,
  input  wire logic                               in_cooling,
  input  wire logic                               in_switch_on,
  input  wire logic                               in_occupied,
  input  wire logic                               in_checked_in,
  input  wire logic                               in_night_mode,
  input  wire logic                               in_precondition,
  // result channel
  output logic                                    out_valid,
  input  wire logic                               out_ready,
  output logic                                    out_acted,
  output logic [fctc_pkg::SPEED_W-1:0]            out_fan_speed,
  output logic [1:0]                              out_zone_mode,
  output logic                                    out_mode_changed
);

  // control path chosen from the occupancy flags
  typedef enum logic [1:0] {
    CTL_EMPTY_OFF,
    CTL_EMPTY,
    CTL_SETBACK,
    CTL_STAY
  } ctl_t;

  // configuration registers
  logic [7:0] setback_offset_r;
  logic [7:0] empty_heat_ref_r;
  logic [7:0] empty_cool_ref_r;
  logic [7:0] fixed_speeds_r;
  logic [3:0] simul_mask_r;

  // per-zone state
  logic [fctc_pkg::SPEED_W-1:0] zone_speed_r [fctc_pkg::ZONE_COUNT];
  fctc_pkg::zone_mode_t         cur_mode_r   [fctc_pkg::ZONE_COUNT];
  fctc_pkg::zone_mode_t         rep_mode_r   [fctc_pkg::ZONE_COUNT];

  // input register
  logic                         s1_valid_r;
  logic [fctc_pkg::ZONE_W-1:0]  s1_zone_r;
  logic                         s1_trigger_r;
  logic [fctc_pkg::TEMP_W-1:0]  s1_set_r;
  logic [fctc_pkg::TEMP_W-1:0]  s1_cur_r;
  logic                         s1_cool_r;
  logic                         s1_sw_r;
  logic                         s1_occ_r;
  logic                         s1_chk_r;
  logic                         s1_night_r;
  logic                         s1_pre_r;

  // result register
  logic                         out_valid_r;
  logic                         out_acted_r;
  logic [fctc_pkg::SPEED_W-1:0] out_speed_r;
  fctc_pkg::zone_mode_t         out_mode_r;
  logic                         out_changed_r;

  // handshake
  logic in_accept;
  logic s1_adv;
  logic s1_fire;
  logic cfg_accept;

  assign cfg_ready  = 1'b1;
  assign cfg_accept = cfg_valid && cfg_ready;
  assign s1_adv     = !out_valid_r || out_ready;
  assign in_ready   = !s1_valid_r || s1_adv;
  assign in_accept  = in_valid && in_ready;
  assign s1_fire    = s1_valid_r && s1_adv;

  // decision logic
  logic                          eval;
  ctl_t                          ctl;
  logic [fctc_pkg::TENTHS_W-1:0] set_t;
  logic [fctc_pkg::TENTHS_W-1:0] cur_t;
  logic [fctc_pkg::TENTHS_W-1:0] offs_t;
  logic [fctc_pkg::TENTHS_W-1:0] ref_t;
  logic [fctc_pkg::TENTHS_W-1:0] hi;
  logic [fctc_pkg::TENTHS_W-1:0] lo;
  logic [fctc_pkg::TENTHS_W-1:0] diff;
  logic [fctc_pkg::SPEED_W-1:0]  old_speed;
  logic [fctc_pkg::SPEED_W-1:0]  fix_speed;
  logic                          apply;
  logic [fctc_pkg::SPEED_W-1:0]  auto_speed;
  logic [fctc_pkg::SPEED_W-1:0]  speed_nxt;
  fctc_pkg::zone_mode_t          mode_nxt;
  logic                          changed;

  always_comb begin
    set_t     = fctc_pkg::tenths(s1_set_r);
    cur_t     = fctc_pkg::tenths(s1_cur_r);
    offs_t    = {3'b0, setback_offset_r};
    ref_t     = s1_cool_r ? fctc_pkg::bcd_tenths(empty_cool_ref_r)
                          : fctc_pkg::bcd_tenths(empty_heat_ref_r);
    old_speed = zone_speed_r[s1_zone_r];
    fix_speed = fixed_speeds_r[{s1_zone_r, 1'b0} +: 2];
    eval      = s1_trigger_r && (s1_cool_r || simul_mask_r[s1_zone_r]);

    // mode choice from occupancy
    if (s1_occ_r) begin
      ctl = s1_night_r ? CTL_SETBACK : (s1_sw_r ? CTL_STAY : CTL_EMPTY_OFF);
    end else if (s1_chk_r) begin
      ctl = s1_sw_r ? CTL_SETBACK : CTL_EMPTY_OFF;
    end else begin
      ctl = s1_pre_r ? CTL_SETBACK : CTL_EMPTY;
    end

    // demand side in hi, other side in lo
    case (ctl)
      CTL_EMPTY: begin
        hi = s1_cool_r ? cur_t : ref_t;
        lo = s1_cool_r ? ref_t : cur_t;
      end
      CTL_SETBACK: begin
        hi = s1_cool_r ? cur_t : set_t;
        lo = s1_cool_r ? (set_t + offs_t) : (cur_t + offs_t);
      end
      default: begin
        hi = s1_cool_r ? cur_t : set_t;
        lo = s1_cool_r ? set_t : cur_t;
      end
    endcase
    diff = hi - lo;

    // automatic speed, apply low means keep the stored speed
    apply      = 1'b0;
    auto_speed = fctc_pkg::SPEED_OFF;
    case (ctl)
      CTL_EMPTY_OFF: begin
        apply = 1'b1;
      end
      CTL_EMPTY: begin
        if (hi > lo) begin
          if (diff > fctc_pkg::BAND_DEAD) begin
            apply      = 1'b1;
            auto_speed = fctc_pkg::SPEED_HIGH;
          end
        end else if (hi < lo) begin
          apply = 1'b1;
        end
      end
      default: begin
        if (hi > lo) begin
          if (diff > fctc_pkg::BAND_DEAD) begin
            apply = 1'b1;
            if (diff > fctc_pkg::BAND_HIGH) begin
              auto_speed = fctc_pkg::SPEED_HIGH;
            end else if (diff <= fctc_pkg::BAND_LOW) begin
              auto_speed = fctc_pkg::SPEED_LOW;
            end else if (diff <= fctc_pkg::BAND_MID) begin
              auto_speed = fctc_pkg::SPEED_MID;
            end else begin
              auto_speed = fctc_pkg::SPEED_HIGH;
            end
          end else if (old_speed != fctc_pkg::SPEED_OFF) begin
            apply      = 1'b1;
            auto_speed = fctc_pkg::SPEED_LOW;
          end
        end else if (hi < lo) begin
          apply = 1'b1;
        end
      end
    endcase

    // fixed speed overrides any running automatic speed
    if (!apply) begin
      speed_nxt = old_speed;
    end else if (fix_speed == fctc_pkg::SPEED_OFF || auto_speed == fctc_pkg::SPEED_OFF) begin
      speed_nxt = auto_speed;
    end else begin
      speed_nxt = fix_speed;
    end

    case (ctl)
      CTL_SETBACK: mode_nxt = fctc_pkg::MODE_SETBACK;
      CTL_STAY:    mode_nxt = fctc_pkg::MODE_STAY;
      default:     mode_nxt = fctc_pkg::MODE_EMPTY;
    endcase
    changed = mode_nxt != rep_mode_r[s1_zone_r];
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      setback_offset_r <= '0;
      empty_heat_ref_r <= '0;
      empty_cool_ref_r <= '0;
      fixed_speeds_r   <= '0;
      simul_mask_r     <= '0;
    end else if (cfg_accept) begin
      case (cfg_index)
        fctc_pkg::REG_SETBACK_OFFSET:    setback_offset_r <= cfg_data;
        fctc_pkg::REG_EMPTY_HEAT_REF:    empty_heat_ref_r <= cfg_data;
        fctc_pkg::REG_EMPTY_COOL_REF:    empty_cool_ref_r <= cfg_data;
        fctc_pkg::REG_FIXED_SPEEDS:      fixed_speeds_r   <= cfg_data;
        fctc_pkg::REG_SIMULTANEOUS_MASK: simul_mask_r     <= cfg_data[3:0];
        default: ;
      endcase
    end
  end

  // per-zone state update
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < fctc_pkg::ZONE_COUNT; i++) begin
        zone_speed_r[i] <= fctc_pkg::SPEED_OFF;
        cur_mode_r[i]   <= fctc_pkg::MODE_EMPTY;
        rep_mode_r[i]   <= fctc_pkg::MODE_EMPTY;
      end
    end else if (s1_fire && eval) begin
      zone_speed_r[s1_zone_r] <= speed_nxt;
      cur_mode_r[s1_zone_r]   <= mode_nxt;
      rep_mode_r[s1_zone_r]   <= mode_nxt;
    end
  end

  // valid flags
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_accept) begin
        s1_valid_r <= 1'b1;
      end else if (s1_adv) begin
        s1_valid_r <= 1'b0;
      end
      if (s1_fire) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // input word register
  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_zone_r    <= in_zone;
      s1_trigger_r <= in_trigger;
      s1_set_r     <= in_set_temp;
      s1_cur_r     <= in_current_temp;
      s1_cool_r    <= in_cooling;
      s1_sw_r      <= in_switch_on;
      s1_occ_r     <= in_occupied;
      s1_chk_r     <= in_checked_in;
      s1_night_r   <= in_night_mode;
      s1_pre_r     <= in_precondition;
    end
  end

  // result word register
  always_ff @(posedge clk) begin
    if (s1_fire) begin
      out_acted_r   <= eval;
      out_speed_r   <= eval ? speed_nxt : old_speed;
      out_mode_r    <= eval ? mode_nxt : cur_mode_r[s1_zone_r];
      out_changed_r <= eval && changed;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_acted        = out_acted_r;
  assign out_fan_speed    = out_speed_r;
  assign out_zone_mode    = out_mode_r;
  assign out_mode_changed = out_changed_r;

  `include "fan_coil_thermostat_control_assert.svh"

  // a word that was not evaluated never reports a mode change
  `FCTC_ASSERT_NOW(a_idle_no_change, out_valid_r && !out_acted_r, !out_changed_r,
    "mode change flagged on a word that was not evaluated")

  // an evaluated word leaves the reported mode equal to the current mode
  `FCTC_ASSERT_NEXT(a_report_sync, s1_fire && eval,
    rep_mode_r[$past(s1_zone_r)] == cur_mode_r[$past(s1_zone_r)],
    "reported mode out of step with current mode after evaluation")

  // an empty result register never blocks the input side
  `FCTC_ASSERT_NOW(a_ready_when_empty, !out_valid_r, in_ready,
    "input stalled while result register is empty")

endmodule

`default_nettype wire
